// ===== hdl/bvhs_pkg.sv =====
// Shared types and constants of the byte value histogram with rank select.
`timescale 1ns / 1ps

package bvhs_pkg;

    localparam int NUM_VALUES    = 256;
    localparam int VALUE_W       = $clog2(NUM_VALUES);
    localparam int DIST_W        = $clog2(NUM_VALUES + 1);
    localparam int SEEN_COUNT_W  = 32;
    localparam int COUNT_W_DEF   = 32;
    localparam int CHUNK_W       = 16;
    localparam int NUM_CHUNKS    = NUM_VALUES / CHUNK_W;
    localparam int CHUNK_IDX_W   = $clog2(NUM_CHUNKS);
    localparam int BIT_IDX_W     = $clog2(CHUNK_W);
    localparam int POP_W         = $clog2(CHUNK_W + 1);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_SELECT = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t            req_type;
        logic [VALUE_W-1:0]   byte_value;
        logic [VALUE_W-1:0]   rank_index;
    } req_t;

    typedef struct packed {
        logic                    is_new;
        logic [SEEN_COUNT_W-1:0] seen_count;
        logic [DIST_W-1:0]       distinct_count;
        logic [VALUE_W-1:0]      selected_value;
        logic                    found;
    } rsp_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] rank;
    } sel_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
    } sel_stat_t;

endpackage

// ===== hdl/bvhs_req_if.sv =====
// Request channel interface carrying valid, ready and the request payload.
`timescale 1ns / 1ps

interface bvhs_req_if;
    logic          valid;
    logic          ready;
    bvhs_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bvhs_rsp_if.sv =====
// Result channel interface carrying valid, ready and the result payload.
`timescale 1ns / 1ps

interface bvhs_rsp_if;
    logic          valid;
    logic          ready;
    bvhs_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bvhs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bvhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/bvhs_rank_sel.sv =====
// Rank select unit that walks the occupancy map one chunk, then one bit, per cycle.
`timescale 1ns / 1ps

module bvhs_rank_sel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bvhs_pkg::NUM_VALUES-1:0]   occ_map,
    input  bvhs_pkg::sel_ctrl_t               ctrl,
    output bvhs_pkg::sel_stat_t               stat
);

    localparam int CIDX_W = bvhs_pkg::CHUNK_IDX_W;
    localparam int BIDX_W = bvhs_pkg::BIT_IDX_W;
    localparam int DW     = bvhs_pkg::DIST_W;
    localparam int VW     = bvhs_pkg::VALUE_W;
    localparam int PW     = bvhs_pkg::POP_W;
    localparam int CW     = bvhs_pkg::CHUNK_W;

    typedef enum logic [1:0] {
        R_IDLE,
        R_CHUNK,
        R_BIT
    } rstate_t;

    rstate_t             state_reg, state_next;
    logic [CIDX_W-1:0]   chunk_reg, chunk_next;
    logic [BIDX_W-1:0]   bit_reg, bit_next;
    logic [BIDX_W-1:0]   remain_reg, remain_next;
    logic [DW-1:0]       passed_reg, passed_next;
    logic [VW-1:0]       rank_reg, rank_next;
    logic                done_reg, done_next;
    logic [VW-1:0]       value_reg, value_next;

    logic [CW-1:0]       chunk_bits;
    logic [PW-1:0]       pop;
    logic [DW-1:0]       sum;
    logic [DW-1:0]       diff;
    logic [VW-1:0]       bit_idx;

    assign chunk_bits = occ_map[chunk_reg * CW +: CW];
    assign bit_idx    = {chunk_reg, bit_reg};

    always_comb
    begin
        pop = '0;
        for (int i = 0; i < CW; i++)
        begin
            pop = pop + PW'(chunk_bits[i]);
        end
    end

    assign sum  = passed_reg + DW'(pop);
    assign diff = DW'(rank_reg) - passed_reg;

    always_comb
    begin
        state_next  = state_reg;
        chunk_next  = chunk_reg;
        bit_next    = bit_reg;
        remain_next = remain_reg;
        passed_next = passed_reg;
        rank_next   = rank_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (ctrl.start)
                begin
                    rank_next   = ctrl.rank;
                    chunk_next  = '0;
                    passed_next = '0;
                    state_next  = R_CHUNK;
                end
            end
            R_CHUNK:
            begin
                if (DW'(rank_reg) < sum)
                begin
                    remain_next = diff[BIDX_W-1:0];
                    bit_next    = '0;
                    state_next  = R_BIT;
                end
                else
                begin
                    passed_next = sum;
                    chunk_next  = chunk_reg + 1'b1;
                end
            end
            R_BIT:
            begin
                if (occ_map[bit_idx])
                begin
                    if (remain_reg == '0)
                    begin
                        done_next  = 1'b1;
                        value_next = bit_idx;
                        state_next = R_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - 1'b1;
                    end
                end
                bit_next = bit_reg + 1'b1;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chunk_reg  <= chunk_next;
        bit_reg    <= bit_next;
        remain_reg <= remain_next;
        passed_reg <= passed_next;
        rank_reg   <= rank_next;
        value_reg  <= value_next;
    end

    assign stat.done  = done_reg;
    assign stat.value = value_reg;

endmodule

// ===== hdl/byte_value_histogram_select_core.sv =====
// Byte value histogram: 256 occurrence counters in RAM with rank select.
// Add and query: RAM read, result register loaded in the update state; next request taken after the push.
// Select: a chunk walk over the occupancy map (16 values per cycle), then a bit walk inside
// the hit chunk; an out-of-range select skips both walks and goes straight to the push state.
// Clear: the occupancy flops clear when the request is taken and so mark all counters as zero.
// Reset: asynchronous, clears occupancy and distinct count at once, no clearing pass.
`timescale 1ns / 1ps

module byte_value_histogram_select_core #(
    parameter int COUNT_WIDTH = bvhs_pkg::COUNT_W_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bvhs_req_if.sink  req,
    bvhs_rsp_if.source rsp
);

    localparam int NV     = bvhs_pkg::NUM_VALUES;
    localparam int VW     = bvhs_pkg::VALUE_W;
    localparam int DW     = bvhs_pkg::DIST_W;
    localparam int SCW    = bvhs_pkg::SEEN_COUNT_W;
    localparam int SEEN_W = (COUNT_WIDTH < SCW) ? COUNT_WIDTH : SCW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_PUSH
    } state_t;

    state_t                  state_reg, state_next;
    bvhs_pkg::req_kind_t     op_reg, op_next;
    logic [VW-1:0]           byte_reg, byte_next;
    logic [NV-1:0]           map_reg, map_next;
    logic [DW-1:0]           distinct_reg, distinct_next;
    bvhs_pkg::rsp_t          res_reg, res_next;
    bvhs_pkg::rsp_t          out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    accept;
    logic                    ram_we;
    logic                    ram_re;
    logic [COUNT_WIDTH-1:0]  ram_rdata;
    logic [COUNT_WIDTH-1:0]  cnt_cur;
    logic [COUNT_WIDTH-1:0]  cnt_new;
    bvhs_pkg::sel_ctrl_t     sel_ctrl;
    bvhs_pkg::sel_stat_t     sel_stat;

    bvhs_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NV)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (byte_reg),
        .wdata (cnt_new),
        .re    (ram_re),
        .raddr (req.data.byte_value),
        .rdata (ram_rdata)
    );

    bvhs_rank_sel u_rank_sel (
        .clk     (clk),
        .rst_n   (rst_n),
        .occ_map (map_reg),
        .ctrl    (sel_ctrl),
        .stat    (sel_stat)
    );

    // A counter whose occupancy bit is clear reads as zero.
    assign cnt_cur = map_reg[byte_reg] ? ram_rdata : '0;
    assign cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.data      = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        byte_next      = byte_reg;
        map_next       = map_reg;
        distinct_next  = distinct_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        sel_ctrl.start = 1'b0;
        sel_ctrl.rank  = req.data.rank_index;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = req.data.req_type;
                    byte_next = req.data.byte_value;
                    res_next  = '0;
                    case (req.data.req_type)
                        bvhs_pkg::REQ_ADD,
                        bvhs_pkg::REQ_QUERY:
                        begin
                            ram_re     = 1'b1;
                            state_next = S_UPDATE;
                        end
                        bvhs_pkg::REQ_SELECT:
                        begin
                            if (DW'(req.data.rank_index) < distinct_reg)
                            begin
                                sel_ctrl.start = 1'b1;
                                state_next     = S_SCAN;
                            end
                            else
                            begin
                                res_next.distinct_count = distinct_reg;
                                state_next              = S_PUSH;
                            end
                        end
                        bvhs_pkg::REQ_CLEAR:
                        begin
                            map_next      = '0;
                            distinct_next = '0;
                            state_next    = S_PUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_UPDATE:
            begin
                if (op_reg == bvhs_pkg::REQ_ADD)
                begin
                    ram_we             = 1'b1;
                    map_next[byte_reg] = 1'b1;
                    res_next.seen_count = SCW'(cnt_new[SEEN_W-1:0]);
                    if (cnt_cur == '0)
                    begin
                        res_next.is_new = 1'b1;
                        if (distinct_reg < DW'(NV))
                        begin
                            distinct_next = distinct_reg + 1'b1;
                        end
                    end
                    res_next.distinct_count = distinct_next;
                end
                else
                begin
                    res_next.seen_count     = SCW'(cnt_cur[SEEN_W-1:0]);
                    res_next.distinct_count = distinct_reg;
                end
                state_next = S_PUSH;
            end
            S_SCAN:
            begin
                if (sel_stat.done)
                begin
                    res_next.selected_value = sel_stat.value;
                    res_next.found          = 1'b1;
                    res_next.distinct_count = distinct_reg;
                    state_next              = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            map_reg       <= '0;
            distinct_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            distinct_reg  <= distinct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        byte_reg <= byte_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule
